### rtl/core/mm64b_pkg.sv
package mm64b_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned LengthW = 31;
  localparam int unsigned HashW   = 64;
  localparam int unsigned InDataW = 72;

  localparam logic [WordW-1:0] MIX_M = 32'h5bd1e995;

  localparam int unsigned MIX_R  = 24;
  localparam int unsigned FIN_R0 = 18;
  localparam int unsigned FIN_R1 = 22;
  localparam int unsigned FIN_R2 = 17;
  localparam int unsigned FIN_R3 = 19;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_K1   = 4'd1,
    OP_K2   = 4'd2,
    OP_FOLD = 4'd3,
    OP_TAIL = 4'd4,
    OP_F0   = 4'd5,
    OP_F1   = 4'd6,
    OP_F2   = 4'd7,
    OP_F3   = 4'd8
  } mm64b_op_t;

  typedef struct packed {
    logic      load;
    mm64b_op_t op;
  } mm64b_cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_part;
    logic in_last;
    logic last;
    logic out_valid;
  } mm64b_status_t;

  function automatic logic [WordW-1:0] tail_mask(input logic [1:0] n);
    logic [WordW-1:0] m;
    begin
      case (n)
        2'd1:    m = 32'h0000_00ff;
        2'd2:    m = 32'h0000_ffff;
        2'd3:    m = 32'h00ff_ffff;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

### rtl/core/murmur64b_string_hash.sv
// Channel   Dir  Handshake                      Content
// s_axis    in   s_axis_tvalid / s_axis_tready  key word, byte count, length; first flag, last
// m_axis    out  m_axis_tvalid / m_axis_tready  64-bit hash {h1, h2}
// seed_wr   in   seed_wr_en                     32-bit seed, write only
//
// A full word is accepted and then makes three passes (K1, K2, FOLD) through the one
// 32x32 constant multiplier, a tail word one pass (TAIL), an empty word none; a last
// word adds the finalize passes F0 to F3. All of these passes share that multiplier.
// rst is synchronous; it clears the seed, h1, h2 and the word parity.
// A waiting hash does not block input; only the final finalize step (F3) holds while
// the output register is still full, and no new word is accepted while it holds.
module murmur64b_string_hash
  import mm64b_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               seed_wr_en,
  input  logic [WordW-1:0]   seed_wr_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] key_word, [34:32] valid_bytes, [65:35] key_length, [71:66] zero
  input  logic [InDataW-1:0] s_axis_tdata,
  // [0] first_word
  input  logic               s_axis_tuser,
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [63:0] hash_value
  output logic [HashW-1:0]   m_axis_tdata
);

  mm64b_cmd_t    cmd;
  mm64b_status_t status;

  mm64b_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mm64b_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .in_word      (s_axis_tdata[WordW-1:0]),
    .in_nbytes    (s_axis_tdata[WordW+CountW-1:WordW]),
    .in_first     (s_axis_tuser),
    .in_last      (s_axis_tlast),
    .in_length    (s_axis_tdata[WordW+CountW+LengthW-1:WordW+CountW]),
    .cmd          (cmd),
    .out_ready    (m_axis_tready),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_data     (m_axis_tdata)
  );

endmodule

### rtl/core/mm64b_dp.sv
module mm64b_dp
  import mm64b_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                seed_wr_en,
  input  logic [WordW-1:0]    seed_wr_data,
  input  logic [WordW-1:0]    in_word,
  input  logic [CountW-1:0]   in_nbytes,
  input  logic                in_first,
  input  logic                in_last,
  input  logic [LengthW-1:0]  in_length,
  input  mm64b_cmd_t          cmd,
  input  logic                out_ready,
  output mm64b_status_t       status,
  output logic                out_valid,
  output logic [HashW-1:0]    out_data
);

  logic [WordW-1:0]  seed;
  logic [WordW-1:0]  word_r;
  logic [1:0]        nbytes_r;
  logic              last_r;
  logic [WordW-1:0]  acc_high;
  logic [WordW-1:0]  acc_low;
  logic              odd_word;
  logic [WordW-1:0]  t_r;
  logic [WordW-1:0]  f1;
  logic [WordW-1:0]  f2;
  logic [WordW-1:0]  mul_a;
  logic [WordW-1:0]  mul_p;

  always_comb begin
    case (cmd.op)
      OP_K1:   mul_a = word_r;
      OP_K2:   mul_a = t_r ^ (t_r >> MIX_R);
      OP_FOLD: mul_a = odd_word ? acc_low : acc_high;
      OP_TAIL: mul_a = acc_low ^ (word_r & tail_mask(nbytes_r));
      OP_F0:   mul_a = acc_high ^ (acc_low >> FIN_R0);
      OP_F1:   mul_a = f2 ^ (f1 >> FIN_R1);
      OP_F2:   mul_a = f1 ^ (f2 >> FIN_R2);
      OP_F3:   mul_a = f2 ^ (f1 >> FIN_R3);
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * MIX_M;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= '0;
      acc_high <= '0;
      acc_low  <= '0;
      odd_word <= 1'b0;
    end else begin
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end
      if (cmd.load && in_first) begin
        acc_high <= seed ^ {1'b0, in_length};
        acc_low  <= '0;
        odd_word <= 1'b0;
      end
      case (cmd.op)
        OP_FOLD: begin
          if (odd_word) begin
            acc_low <= mul_p ^ t_r;
          end else begin
            acc_high <= mul_p ^ t_r;
          end
          odd_word <= ~odd_word;
        end
        OP_TAIL: acc_low <= mul_p;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r   <= in_word;
      nbytes_r <= in_nbytes[1:0];
      last_r   <= in_last;
    end
    case (cmd.op)
      OP_K1, OP_K2: t_r <= mul_p;
      OP_F0: begin
        f1 <= mul_p;
        f2 <= acc_low;
      end
      OP_F1:   f2 <= mul_p;
      OP_F2:   f1 <= mul_p;
      OP_F3:   out_data <= {f1, mul_p};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_F3) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.in_full   = in_nbytes[2];
  assign status.in_part   = !in_nbytes[2] && (in_nbytes[1:0] != 2'd0);
  assign status.in_last   = in_last;
  assign status.last      = last_r;
  assign status.out_valid = out_valid;

endmodule

### rtl/core/mm64b_ctrl.sv
module mm64b_ctrl
  import mm64b_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  mm64b_status_t status,
  output mm64b_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_K1   = 9'b000000010,
    S_K2   = 9'b000000100,
    S_FOLD = 9'b000001000,
    S_TAIL = 9'b000010000,
    S_F0   = 9'b000100000,
    S_F1   = 9'b001000000,
    S_F2   = 9'b010000000,
    S_F3   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !status.out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_full) begin
            state_next = S_K1;
          end else if (status.in_part) begin
            state_next = S_TAIL;
          end else if (status.in_last) begin
            state_next = S_F0;
          end
        end
      end
      S_K1: begin
        cmd.op     = OP_K1;
        state_next = S_K2;
      end
      S_K2: begin
        cmd.op     = OP_K2;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.op     = OP_FOLD;
        state_next = status.last ? S_F0 : S_IDLE;
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = status.last ? S_F0 : S_IDLE;
      end
      S_F0: begin
        cmd.op     = OP_F0;
        state_next = S_F1;
      end
      S_F1: begin
        cmd.op     = OP_F1;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.op     = OP_F2;
        state_next = S_F3;
      end
      S_F3: begin
        if (out_free) begin
          cmd.op     = OP_F3;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
